// ===== rtl/core/ppne_pkg.sv =====
// package for the point-plane normal equation accumulator
// types, register indexes and field widths; no dependencies
package ppne_pkg;
    localparam int ACC_WIDTH_DEF  = 64;
    localparam int MAX_POINTS_DEF = 65535;
    localparam int NUM_SUMS       = 28;
    localparam int NUM_H          = 21;
    localparam int NUM_TERMS      = 28;

    typedef enum logic [2:0] {
        REG_ROT_A   = 3'd0,
        REG_ROT_B   = 3'd1,
        REG_ROT_C   = 3'd2,
        REG_ROT_D   = 3'd3,
        REG_ROT_L   = 3'd4,
        REG_TRANS_XY = 3'd5,
        REG_TRANS_Z = 3'd6,
        REG_WEIGHT  = 3'd7
    } reg_index_t;

    // correspondence item handed from the input channel to the front
    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic signed [31:0] nx, ny, nz;
        logic signed [31:0] d;
        logic              last;
    } item_t;

    // jacobian and residual handed to the accumulators
    typedef struct packed {
        logic signed [31:0] j0, j1, j2, j3, j4, j5;
        logic signed [31:0] e;
        logic              sat;
        logic              last;
    } jac_t;

    function automatic logic signed [31:0] clamp32(input logic signed [35:0] v,
                                                   output logic sat);
        sat = 1'b0;
        if (v > 36'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        else if (v < -36'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // floor of a 64-bit product shifted by 30, narrowed to 36 bits
    function automatic logic signed [35:0] sh30(input logic signed [63:0] v);
        return 36'(v >>> 30);
    endfunction
endpackage

// ===== rtl/core/ppne_fifo.sv =====
// short queue between front and back
// depends on nothing but its parameters
module ppne_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
                wp_reg <= ~wp_reg;
            if (out_valid && out_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            mem_reg[wp_reg] <= in_data;
    end
endmodule

// ===== rtl/core/ppne_front.sv =====
// front: takes correspondences, forms residual and jacobian
// in rotation, residual and cross steps; depends on ppne_pkg
module ppne_front import ppne_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  item_t              in_item,
    input  logic signed [31:0] rot [9],
    input  logic signed [31:0] trans [3],
    output logic               out_valid,
    input  logic               out_ready,
    output jac_t               out_jac
);
    typedef enum logic [2:0] {S_IDLE, S_ROT, S_RES, S_CROSS, S_OUT} state_t;

    state_t             state_reg;
    item_t              it_reg;
    logic signed [31:0] wld_reg [3];
    logic signed [31:0] nb_reg [3];
    logic signed [31:0] e_reg;
    logic signed [35:0] eacc_reg;
    logic signed [31:0] jc_reg [3];
    logic               sat_reg;
    logic [1:0]         idx_reg;

    // one row of the rotation per step: world row and transposed normal row
    logic signed [31:0] pv [3], nv [3];
    logic signed [35:0] ssum, qsum, esum, csum;
    logic signed [31:0] wc, qc, ec, cc;
    logic               ws, qs, es, cs;
    logic signed [31:0] ca, cb, cc1, cd;

    always_comb
    begin
        pv[0] = it_reg.px; pv[1] = it_reg.py; pv[2] = it_reg.pz;
        nv[0] = it_reg.nx; nv[1] = it_reg.ny; nv[2] = it_reg.nz;
        ssum = 36'(trans[idx_reg]);
        qsum = '0;
        for (int j = 0; j < 3; j++)
        begin
            ssum += sh30(64'(rot[idx_reg*3+j]) * 64'(pv[j]));
            qsum += sh30(64'(rot[j*3+idx_reg]) * 64'(nv[j]));
        end
        wc = clamp32(ssum, ws);
        qc = clamp32(qsum, qs);
        esum = eacc_reg + sh30(64'(nv[idx_reg]) * 64'(wld_reg[idx_reg]));
        ec = clamp32(esum, es);
        unique case (idx_reg)
            2'd0:    begin ca = pv[1]; cb = nb_reg[2]; cc1 = pv[2]; cd = nb_reg[1]; end
            2'd1:    begin ca = pv[2]; cb = nb_reg[0]; cc1 = pv[0]; cd = nb_reg[2]; end
            default: begin ca = pv[0]; cb = nb_reg[1]; cc1 = pv[1]; cd = nb_reg[0]; end
        endcase
        csum = sh30(64'(ca) * 64'(cb)) - sh30(64'(cc1) * 64'(cd));
        cc = clamp32(csum, cs);
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_jac = '{j0: jc_reg[0], j1: jc_reg[1], j2: jc_reg[2],
                       j3: it_reg.nx >>> 14, j4: it_reg.ny >>> 14, j5: it_reg.nz >>> 14,
                       e: e_reg, sat: sat_reg, last: it_reg.last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_ROT;
                        idx_reg   <= '0;
                        sat_reg   <= 1'b0;
                    end
                S_ROT:
                begin
                    sat_reg <= sat_reg | ws | qs;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_RES;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                S_RES:
                begin
                    // residual is clamped only once, after all three terms
                    if (idx_reg == 2'd2)
                    begin
                        sat_reg   <= sat_reg | es;
                        idx_reg   <= '0;
                        state_reg <= S_CROSS;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                S_CROSS:
                begin
                    sat_reg <= sat_reg | cs;
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            it_reg   <= in_item;
            eacc_reg <= 36'(in_item.d);
        end
        if (state_reg == S_ROT)
        begin
            wld_reg[idx_reg] <= wc;
            nb_reg[idx_reg]  <= qc;
        end
        if (state_reg == S_RES)
        begin
            // partial residual kept wide until the final clamp
            eacc_reg <= esum;
            if (idx_reg == 2'd2)
                e_reg <= ec;
        end
        if (state_reg == S_CROSS)
            jc_reg[idx_reg] <= cc;
    end
endmodule

// ===== rtl/core/ppne_back.sv =====
// back: one product term at a time into the accumulators, then emits 28 sums
// depends on ppne_pkg
module ppne_back import ppne_pkg::*; #(
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  jac_t        in_jac,
    input  logic [15:0] weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  out_index,
    output logic signed [63:0] out_value,
    output logic [15:0] out_total,
    output logic        out_ovf,
    output logic        out_last
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_EMIT} state_t;
    localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    state_t                      state_reg;
    jac_t                        j_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg [NUM_SUMS];
    logic [15:0]                 cnt_reg;
    logic                        sat_reg;
    logic [4:0]                  k_reg;
    logic [2:0]                  ra_reg, rb_reg;
    logic signed [47:0]          prod_reg;
    logic signed [31:0]          jv [7];
    logic signed [31:0]          op_a, op_b;
    logic signed [63:0]          p64;
    logic signed [65:0]          sum;
    logic signed [65:0]          term;
    logic signed [ACC_WIDTH-1:0] acc_new;
    logic                        acc_sat;

    always_comb
    begin
        jv[0] = j_reg.j0; jv[1] = j_reg.j1; jv[2] = j_reg.j2;
        jv[3] = j_reg.j3; jv[4] = j_reg.j4; jv[5] = j_reg.j5; jv[6] = j_reg.e;
        op_a = jv[ra_reg];
        op_b = jv[rb_reg];
        p64  = 64'(op_a) * 64'(op_b);
        // floor product / 2^16 times weight fits in 64 bits
        term = 66'(prod_reg) * 66'($signed({1'b0, weight}));
        if (k_reg >= 5'(NUM_H) && k_reg < 5'(NUM_SUMS - 1))
            term = -term;
        sum = 66'(acc_reg[k_reg]) + term;
        acc_sat = 1'b0;
        acc_new = sum[ACC_WIDTH-1:0];
        if (sum > 66'(ACC_HI))
        begin
            acc_new = ACC_HI;
            acc_sat = 1'b1;
        end
        else if (sum < 66'(ACC_LO))
        begin
            acc_new = ACC_LO;
            acc_sat = 1'b1;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_EMIT;
    assign out_index = k_reg;
    assign out_value = 64'(acc_reg[k_reg]);
    assign out_total = cnt_reg;
    assign out_ovf   = sat_reg;
    assign out_last  = k_reg == 5'(NUM_SUMS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            ra_reg    <= '0;
            rb_reg    <= '0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
            for (int i = 0; i < NUM_SUMS; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        state_reg <= S_MUL;
                        k_reg     <= '0;
                        ra_reg    <= '0;
                        rb_reg    <= '0;
                        sat_reg   <= sat_reg | in_jac.sat;
                        if (cnt_reg < 16'(MAX_POINTS))
                            cnt_reg <= cnt_reg + 16'd1;
                    end
                S_MUL:
                    state_reg <= S_ADD;
                S_ADD:
                begin
                    acc_reg[k_reg] <= acc_new;
                    sat_reg        <= sat_reg | acc_sat;
                    if (k_reg == 5'(NUM_SUMS - 1))
                    begin
                        k_reg     <= '0;
                        state_reg <= j_reg.last ? S_EMIT : S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 5'd1;
                        state_reg <= S_MUL;
                        // walk the upper triangle, then jacobian times residual, then e*e
                        if (k_reg < 5'(NUM_H - 1))
                        begin
                            if (rb_reg == 3'd5)
                            begin
                                ra_reg <= ra_reg + 3'd1;
                                rb_reg <= ra_reg + 3'd1;
                            end
                            else
                                rb_reg <= rb_reg + 3'd1;
                        end
                        else if (k_reg == 5'(NUM_H - 1))
                        begin
                            ra_reg <= 3'd0;
                            rb_reg <= 3'd6;
                        end
                        else if (ra_reg == 3'd5)
                            ra_reg <= 3'd6;
                        else
                            ra_reg <= ra_reg + 3'd1;
                    end
                end
                S_EMIT:
                    if (out_ready)
                    begin
                        if (k_reg == 5'(NUM_SUMS - 1))
                        begin
                            state_reg <= S_IDLE;
                            k_reg     <= '0;
                            cnt_reg   <= '0;
                            sat_reg   <= 1'b0;
                            for (int i = 0; i < NUM_SUMS; i++)
                                acc_reg[i] <= '0;
                        end
                        else
                            k_reg <= k_reg + 5'd1;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            j_reg <= in_jac;
        if (state_reg == S_MUL)
            prod_reg <= 48'(p64 >>> 16);
    end
endmodule

// ===== rtl/core/point_plane_normal_eq_accum.sv =====
// top level of the point-to-plane normal equation accumulator
// depends on ppne_pkg, ppne_front, ppne_fifo, ppne_back
//
// channels: s_axis takes one correspondence per word; cfg writes the pose
// and weight registers (index 0..7); the user must write them only while
// the block is idle, which the block itself does not enforce; m_axis
// returns the 28 sums after a word marked with tlast.
// the front forms residual and jacobian (six multipliers in the rotation
// steps, three in the residual and cross steps); the back does one multiply
// then one saturating add per sum, takes a new word only after its last sum
// and so sets the sustained word rate. a two-deep queue between front and
// back lets the front take the next word while the back still accumulates
// or emits. after a last word, 28 result words follow in index order, the
// final one with tlast; then all sums, count and flag are cleared.
// when m_axis stalls the back holds its current sum and the queue fills,
// then s_axis_tready drops.
// reset: identity rotation, zero translation, weight 1000, sums cleared.
module point_plane_normal_eq_accum import ppne_pkg::*; #(
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z, plane_offset
    input  logic [223:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sum_index[4:0], sum_value[68:5], point_total[84:69], overflow[85], pad
    output logic [87:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    logic [63:0] rot_a_reg, rot_b_reg, rot_c_reg, rot_d_reg, trans_xy_reg;
    logic [31:0] rot_l_reg, trans_z_reg;
    logic [15:0] weight_reg;
    logic signed [31:0] rot [9];
    logic signed [31:0] trans [3];
    item_t item;
    jac_t  f_jac, q_jac;
    logic  f_valid, f_ready, q_valid, q_ready;
    logic [4:0] idx;
    logic signed [63:0] val;
    logic [15:0] tot;
    logic ovf;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_a_reg    <= 64'd1073741824;
            rot_b_reg    <= '0;
            rot_c_reg    <= 64'd1073741824;
            rot_d_reg    <= '0;
            rot_l_reg    <= 32'd1073741824;
            trans_xy_reg <= '0;
            trans_z_reg  <= '0;
            weight_reg   <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ROT_A:    rot_a_reg    <= cfg_data;
                REG_ROT_B:    rot_b_reg    <= cfg_data;
                REG_ROT_C:    rot_c_reg    <= cfg_data;
                REG_ROT_D:    rot_d_reg    <= cfg_data;
                REG_ROT_L:    rot_l_reg    <= cfg_data[31:0];
                REG_TRANS_XY: trans_xy_reg <= cfg_data;
                REG_TRANS_Z:  trans_z_reg  <= cfg_data[31:0];
                REG_WEIGHT:   weight_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rot[0] = rot_a_reg[31:0]; rot[1] = rot_a_reg[63:32];
        rot[2] = rot_b_reg[31:0]; rot[3] = rot_b_reg[63:32];
        rot[4] = rot_c_reg[31:0]; rot[5] = rot_c_reg[63:32];
        rot[6] = rot_d_reg[31:0]; rot[7] = rot_d_reg[63:32];
        rot[8] = rot_l_reg;
        trans[0] = trans_xy_reg[31:0];
        trans[1] = trans_xy_reg[63:32];
        trans[2] = trans_z_reg;
        item = '{px: s_axis_tdata[31:0], py: s_axis_tdata[63:32],
                 pz: s_axis_tdata[95:64], nx: s_axis_tdata[127:96],
                 ny: s_axis_tdata[159:128], nz: s_axis_tdata[191:160],
                 d: s_axis_tdata[223:192], last: s_axis_tlast};
    end

    ppne_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(item),
        .rot(rot), .trans(trans),
        .out_valid(f_valid), .out_ready(f_ready), .out_jac(f_jac)
    );

    ppne_fifo #(.WIDTH($bits(jac_t))) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_jac),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_jac)
    );

    ppne_back #(.ACC_WIDTH(ACC_WIDTH), .MAX_POINTS(MAX_POINTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_jac(q_jac),
        .weight(weight_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_index(idx), .out_value(val), .out_total(tot), .out_ovf(ovf),
        .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, ovf, tot, val, idx};
endmodule

// ===== sim/point_plane_normal_eq_accum_test.sv =====
// testbench for point_plane_normal_eq_accum: streams correspondences, predicts the 28 sums
// per set in a local model and compares every result word; depends on ppne_pkg and the rtl
`timescale 1ns / 100ps

module point_plane_normal_eq_accum_test;
    import ppne_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 450;
    localparam int DRAIN_CYCLES = 200;
    localparam int WANT_DEPTH = 512;
    localparam longint ACC_MAX = 64'sh7fffffffffffffff;
    localparam longint ACC_MIN = 64'sh8000000000000000;

    typedef struct {
        int px, py, pz;
        int nx, ny, nz;
        int d;
        bit last;
    } corr_t;

    typedef struct {
        logic [4:0]  index;
        logic [63:0] value;
        logic [15:0] total;
        logic        ovf;
        logic        last;
    } sum_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    reg_index_t   cfg_index = REG_ROT_A;
    logic [63:0]  cfg_data = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic         m_axis_tlast;

    // pose and weight as the block should hold them
    logic [63:0] pose_regs [8];
    longint      hess_acc [21];
    longint      grad_acc [6];
    longint      cost_acc;
    int          point_cnt;
    bit          sat_flag;
    // expected result words, written at input accept, read at output accept
    sum_word_t   want_buf [WANT_DEPTH];
    int          want_wr = 0;
    int          want_rd = 0;

    int  errors = 0;
    bit  no_idle = 1'b0;
    int  hold_tickets = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;

    point_plane_normal_eq_accum dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint lo32(logic [63:0] v);
        return longint'($signed(v[31:0]));
    endfunction

    function automatic longint hi32(logic [63:0] v);
        return longint'($signed(v[63:32]));
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            sat_flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat_flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint add_sat(longint acc, longint term);
        if (term > 0 && acc > ACC_MAX - term)
        begin
            sat_flag = 1'b1;
            return ACC_MAX;
        end
        if (term < 0 && acc < ACC_MIN - term)
        begin
            sat_flag = 1'b1;
            return ACC_MIN;
        end
        return acc + term;
    endfunction

    function automatic void clear_sums();
        foreach (hess_acc[i]) hess_acc[i] = 0;
        foreach (grad_acc[i]) grad_acc[i] = 0;
        cost_acc = 0;
        point_cnt = 0;
        sat_flag = 1'b0;
    endfunction

    // residual, jacobian and normal-equation update for one correspondence
    function automatic void absorb_correspondence(corr_t c);
        longint r [3][3];
        longint t [3];
        longint p [3];
        longint n [3];
        longint wld [3];
        longint nb [3];
        longint jac [6];
        longint e, w, s, q;
        int k;
        sum_word_t sw;
        r[0][0] = lo32(pose_regs[REG_ROT_A]); r[0][1] = hi32(pose_regs[REG_ROT_A]);
        r[0][2] = lo32(pose_regs[REG_ROT_B]); r[1][0] = hi32(pose_regs[REG_ROT_B]);
        r[1][1] = lo32(pose_regs[REG_ROT_C]); r[1][2] = hi32(pose_regs[REG_ROT_C]);
        r[2][0] = lo32(pose_regs[REG_ROT_D]); r[2][1] = hi32(pose_regs[REG_ROT_D]);
        r[2][2] = lo32(pose_regs[REG_ROT_L]);
        t[0] = lo32(pose_regs[REG_TRANS_XY]);
        t[1] = hi32(pose_regs[REG_TRANS_XY]);
        t[2] = lo32(pose_regs[REG_TRANS_Z]);
        w = longint'(pose_regs[REG_WEIGHT][15:0]);
        p[0] = c.px; p[1] = c.py; p[2] = c.pz;
        n[0] = c.nx; n[1] = c.ny; n[2] = c.nz;
        for (int i = 0; i < 3; i++)
        begin
            s = t[i];
            q = 0;
            for (int j = 0; j < 3; j++)
            begin
                s += (r[i][j] * p[j]) >>> 30;
                q += (r[j][i] * n[j]) >>> 30;
            end
            wld[i] = clip32(s);
            nb[i] = clip32(q);
        end
        e = c.d;
        for (int i = 0; i < 3; i++)
            e += (n[i] * wld[i]) >>> 30;
        e = clip32(e);
        jac[0] = clip32(((p[1] * nb[2]) >>> 30) - ((p[2] * nb[1]) >>> 30));
        jac[1] = clip32(((p[2] * nb[0]) >>> 30) - ((p[0] * nb[2]) >>> 30));
        jac[2] = clip32(((p[0] * nb[1]) >>> 30) - ((p[1] * nb[0]) >>> 30));
        for (int i = 0; i < 3; i++)
            jac[3 + i] = n[i] >>> 14;
        k = 0;
        for (int i = 0; i < 6; i++)
            for (int j = i; j < 6; j++)
            begin
                hess_acc[k] = add_sat(hess_acc[k], w * ((jac[i] * jac[j]) >>> 16));
                k++;
            end
        for (int i = 0; i < 6; i++)
            grad_acc[i] = add_sat(grad_acc[i], -(w * ((jac[i] * e) >>> 16)));
        cost_acc = add_sat(cost_acc, w * ((e * e) >>> 16));
        if (point_cnt < 65535)
            point_cnt++;
        if (!c.last)
            return;
        for (int i = 0; i < NUM_SUMS; i++)
        begin
            sw.index = i[4:0];
            sw.value = i < NUM_H ? hess_acc[i] : (i < 27 ? grad_acc[i - NUM_H] : cost_acc);
            sw.total = point_cnt[15:0];
            sw.ovf = sat_flag;
            sw.last = (i == 27);
            want_buf[want_wr % WANT_DEPTH] = sw;
            want_wr++;
        end
        clear_sums();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_seen != hold_tickets)
        begin
            hold_seen = hold_tickets;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= 36);
    end

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %h got %h", what, want, got);
    endtask

    always @(posedge clk)
    begin
        sum_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (want_wr == want_rd)
                note_mismatch("unexpected word", 64'd0, m_axis_tdata[68:5]);
            else
            begin
                want = want_buf[want_rd % WANT_DEPTH];
                want_rd++;
                if (m_axis_tdata[4:0] !== want.index)
                    note_mismatch("sum_index", 64'(want.index), 64'(m_axis_tdata[4:0]));
                if (m_axis_tdata[68:5] !== want.value)
                    note_mismatch("sum_value", want.value, m_axis_tdata[68:5]);
                if (m_axis_tdata[84:69] !== want.total)
                    note_mismatch("point_total", 64'(want.total), 64'(m_axis_tdata[84:69]));
                if (m_axis_tdata[85] !== want.ovf)
                    note_mismatch("overflow", 64'(want.ovf), 64'(m_axis_tdata[85]));
                if (m_axis_tlast !== want.last)
                    note_mismatch("last_sum", 64'(want.last), 64'(m_axis_tlast));
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("[point_plane_normal_eq_accum] ERROR");
            $finish;
        end
    end

    task automatic send_word(corr_t c);
        if (!no_idle && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c.d, c.nz, c.ny, c.nx, c.pz, c.py, c.px};
        s_axis_tlast <= c.last;
        do @(posedge clk); while (!s_axis_tready);
        absorb_correspondence(c);
    endtask

    // let all sums drain before touching the pose registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (want_wr != want_rd) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pose_regs[idx] = value;
        @(posedge clk);
    endtask

    function automatic int field_value(bit tame, int tame_span);
        int pick;
        pick = $urandom_range(99);
        if (tame && pick < 80)
            return $signed($urandom_range(2 * tame_span)) - tame_span;
        if (pick < 88)
        begin
            case ($urandom_range(4))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic corr_t make_corr(bit tame, bit last);
        corr_t c;
        c.px = field_value(tame, 1 << 22);
        c.py = field_value(tame, 1 << 22);
        c.pz = field_value(tame, 1 << 22);
        c.nx = field_value(tame, 1 << 30);
        c.ny = field_value(tame, 1 << 30);
        c.nz = field_value(tame, 1 << 30);
        c.d = field_value(tame, 1 << 22);
        c.last = last;
        return c;
    endfunction

    task automatic send_set(int count, bit tame);
        for (int i = 0; i < count; i++)
            send_word(make_corr(tame, i == count - 1));
    endtask

    task automatic load_pose(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [63:0] d, logic [31:0] l, logic [63:0] txy,
                             logic [31:0] tz, logic [15:0] w);
        write_reg(REG_ROT_A, a);
        write_reg(REG_ROT_B, b);
        write_reg(REG_ROT_C, c);
        write_reg(REG_ROT_D, d);
        write_reg(REG_ROT_L, {32'd0, l});
        write_reg(REG_TRANS_XY, txy);
        write_reg(REG_TRANS_Z, {32'd0, tz});
        write_reg(REG_WEIGHT, {48'd0, w});
    endtask

    task automatic test_directed();
        corr_t c;
        c = '{0, 0, 0, 0, 0, 0, 0, 1'b1};
        send_word(c);
        c = '{32'sh00010000, 32'sh00020000, -32'sh00030000,
              32'sh40000000, 0, 0, 32'sh00008000, 1'b0};
        send_word(c);
        c = '{-32'sh00010000, 32'sh00005000, 32'sh00040000,
              0, 32'sh40000000, 0, -32'sh00001000, 1'b1};
        send_word(c);
        c = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1};
        send_word(c);
        c = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1};
        send_word(c);
        c = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff, 32'sh80000000, -1, 1'b0};
        send_word(c);
        // accumulator saturation needs several large terms in one set
        for (int i = 0; i < 6; i++)
        begin
            c = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, i == 5};
            send_word(c);
        end
        settle();
    endtask

    task automatic test_pose_sweep();
        // reset values written back explicitly, then translation only
        load_pose(64'h0000_0000_4000_0000, 64'd0, 64'h0000_0000_4000_0000, 64'd0,
                  32'h4000_0000, 64'd0, 32'd0, 16'd1000);
        send_set(4, 1'b1);
        settle();
        load_pose(64'h0000_0000_4000_0000, 64'd0, 64'h0000_0000_4000_0000, 64'd0,
                  32'h4000_0000, {32'sh0001_8000, -32'sh0002_0000}, 32'h0000_4000, 16'd1);
        send_set(5, 1'b1);
        settle();
        // quarter turn about z
        load_pose({32'hc000_0000, 32'd0}, {32'h4000_0000, 32'd0}, 64'd0, 64'd0,
                  32'h4000_0000, {$urandom, $urandom}, $urandom_range(65535), 16'd65535);
        send_set(6, 1'b1);
        settle();
        // extreme values in most registers
        load_pose({32'h7fff_ffff, 32'h8000_0000}, {32'h8000_0000, 32'h7fff_ffff},
                  64'hffff_ffff_ffff_ffff, 64'd0, 32'h8000_0000,
                  {32'h8000_0000, 32'h7fff_ffff}, 32'h7fff_ffff, 16'hffff);
        send_set(3, 1'b0);
        send_set(2, 1'b1);
        settle();
        load_pose(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0, 64'hffff_ffff_ffff_ffff,
                  32'h7fff_ffff, 64'hffff_ffff_ffff_ffff, 32'h8000_0000, 16'd0);
        send_set(4, 1'b1);
        settle();
    endtask

    task automatic test_random_sets();
        int sent;
        sent = 0;
        while (sent < 200)
        begin
            if (sent % 60 == 0)
            begin
                settle();
                load_pose({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, $urandom, {$urandom, $urandom},
                          $urandom, 16'($urandom_range(65535)));
            end
            no_idle = (sent >= 100 && sent < 140);
            if ($urandom_range(9) < 8)
            begin
                send_set($urandom_range(1, 8), 1'b1);
                sent += 4;
            end
            else
            begin
                send_set($urandom_range(1, 5), 1'b0);
                sent += 3;
            end
        end
        no_idle = 1'b0;
        settle();
    endtask

    task automatic test_output_hold();
        // receiver stalls long enough for the queue to fill and tready to drop
        hold_tickets++;
        send_set(4, 1'b1);
        send_set(6, 1'b1);
        settle();
    endtask

    initial
    begin
        pose_regs[REG_ROT_A] = 64'h0000_0000_4000_0000;
        pose_regs[REG_ROT_B] = 64'd0;
        pose_regs[REG_ROT_C] = 64'h0000_0000_4000_0000;
        pose_regs[REG_ROT_D] = 64'd0;
        pose_regs[REG_ROT_L] = 64'h0000_0000_4000_0000;
        pose_regs[REG_TRANS_XY] = 64'd0;
        pose_regs[REG_TRANS_Z] = 64'd0;
        pose_regs[REG_WEIGHT] = 64'd1000;
        clear_sums();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_pose_sweep();
        test_output_hold();
        test_random_sets();
        test_output_hold();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && want_wr == want_rd)
            $display("[point_plane_normal_eq_accum] OK");
        else
            $display("[point_plane_normal_eq_accum] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ppne_pkg.sv
rtl/core/ppne_fifo.sv
rtl/core/ppne_front.sv
rtl/core/ppne_back.sv
rtl/core/point_plane_normal_eq_accum.sv
sim/point_plane_normal_eq_accum_test.sv
